[rtl/core/scrpd_pkg.sv]
// ----------------------------------------------------------------------------
// scrpd_pkg
// Shared codes and controller/datapath interface types for the RGB dimmer.
// ----------------------------------------------------------------------------
package scrpd_pkg;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_Z     = 8'h7A;
  localparam logic [7:0] CHR_R     = 8'h52;
  localparam logic [7:0] CHR_G     = 8'h47;
  localparam logic [7:0] CHR_B     = 8'h42;
  localparam logic [7:0] CHR_E     = 8'h45;
  localparam logic [7:0] CHR_ZERO  = 8'd48;
  localparam logic [7:0] CHR_NINE  = 8'd57;

  localparam logic [2:0] POS_HUNT   = 3'd0;
  localparam logic [2:0] POS_LETTER = 3'd1;
  localparam logic [2:0] POS_DIG1   = 3'd2;
  localparam logic [2:0] POS_DIG3   = 3'd4;
  localparam logic [2:0] POS_Z      = 3'd5;

  localparam logic [1:0] LET_R = 2'd0;
  localparam logic [1:0] LET_G = 2'd1;
  localparam logic [1:0] LET_B = 2'd2;
  localparam logic [1:0] LET_E = 2'd3;

  localparam int LEVEL_W = 10;

  typedef struct packed {
    logic accept;    // input beat taken this cycle
    logic div_step;  // advance the period divider one bit
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_div; // current input beat completes a frame with nonzero level
    logic div_last;  // divider is on its final bit
  } dp_status_t;

endpackage

[rtl/core/scrpd_ctrl.sv]
// ----------------------------------------------------------------------------
// scrpd_ctrl
// Sequencer: accepts beats, holds the output valid, runs the period divide.
// ----------------------------------------------------------------------------
module scrpd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  scrpd_pkg::dp_status_t  status_i,
  output scrpd_pkg::ctrl_cmd_t   cmd_o
);
  import scrpd_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.accept   = accept;
    cmd_o.div_step = (state_q == ST_DIV);
    state_d        = state_q;
    out_valid_d    = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (accept) out_valid_d = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (accept && status_i.needs_div) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/scrpd_dp.sv]
// ----------------------------------------------------------------------------
// scrpd_dp
// Datapath: frame parser, channel levels, pulse counters, serial divider.
// ----------------------------------------------------------------------------
module scrpd_dp #(
  parameter int PULSE_SCALE = 100
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scrpd_pkg::ctrl_cmd_t  cmd_i,
  output scrpd_pkg::dp_status_t status_o,
  input  logic                  op_i,
  input  logic [7:0]            rx_byte_i,
  output logic                  red_on_o,
  output logic                  green_on_o,
  output logic                  blue_on_o,
  output logic                  frame_accepted_o,
  output logic                  frame_rejected_o,
  output logic                  halted_o
);
  import scrpd_pkg::*;

  localparam int SW = $clog2(PULSE_SCALE + 1);
  localparam int CW = (SW > 1) ? $clog2(SW) : 1;
  localparam logic [SW-1:0] SCALE_W = SW'(PULSE_SCALE);
  localparam logic [CW-1:0] LAST_BIT = CW'(SW - 1);

  logic [2:0]         pos_q, pos_d;
  logic [1:0]         letter_q, letter_d;
  logic [LEVEL_W-1:0] acc_q, acc_d;
  logic [LEVEL_W-1:0] level_q [3];
  logic [SW-1:0]      period_q [3];
  logic [SW-1:0]      cnt_q [3];
  logic [SW-1:0]      cnt_d [3];
  logic [2:0]         drive_q, drive_d;
  logic               halt_q, halt_d;
  logic               ev_acc, ev_rej;
  logic               frame_done;

  // divider state
  logic [SW-1:0]      dvd_q;
  logic [LEVEL_W-1:0] rem_q;
  logic [LEVEL_W-1:0] dlv_q;
  logic [1:0]         dch_q;
  logic [CW-1:0]      dcnt_q;
  logic [LEVEL_W:0]   rem_sh;
  logic               ge;
  logic [LEVEL_W:0]   rem_sub;
  logic [SW-1:0]      q_nxt;

  logic               is_digit;
  logic [LEVEL_W+3:0] acc_mul;
  logic [7:0]         digit;

  assign is_digit = (rx_byte_i >= CHR_ZERO) && (rx_byte_i <= CHR_NINE);
  assign digit    = rx_byte_i - CHR_ZERO;
  assign acc_mul  = {4'b0, acc_q} * 14'd10 + {6'b0, digit};

  always_comb begin
    pos_d      = pos_q;
    letter_d   = letter_q;
    acc_d      = acc_q;
    drive_d    = drive_q;
    halt_d     = halt_q;
    ev_acc     = 1'b0;
    ev_rej     = 1'b0;
    frame_done = 1'b0;
    for (int c = 0; c < 3; c++) begin
      cnt_d[c] = cnt_q[c];
    end
    if (!halt_q) begin
      if (op_i == OP_TICK) begin
        for (int c = 0; c < 3; c++) begin
          logic [SW-1:0] base;
          base = cnt_q[c];
          drive_d[c] = (level_q[c] != '0) && (cnt_q[c] >= period_q[c]);
          if (drive_d[c]) base = '0;
          cnt_d[c] = (base < SCALE_W) ? base + SW'(1) : SCALE_W;
        end
      end else begin
        case (pos_q)
          POS_HUNT: begin
            if (rx_byte_i == CHR_COLON) pos_d = POS_LETTER;
          end
          POS_LETTER: begin
            pos_d = POS_DIG1;
            acc_d = '0;
            case (rx_byte_i)
              CHR_R:   letter_d = LET_R;
              CHR_G:   letter_d = LET_G;
              CHR_B:   letter_d = LET_B;
              CHR_E:   letter_d = LET_E;
              default: begin
                pos_d  = POS_HUNT;
                acc_d  = acc_q;
                ev_rej = 1'b1;
              end
            endcase
          end
          default: begin
            if (pos_q >= POS_DIG1 && pos_q <= POS_DIG3) begin
              if (is_digit) begin
                acc_d = acc_mul[LEVEL_W-1:0];
                pos_d = pos_q + 3'd1;
              end else begin
                pos_d  = POS_HUNT;
                ev_rej = 1'b1;
              end
            end else begin
              // terminator slot
              pos_d = POS_HUNT;
              if (rx_byte_i != CHR_Z) begin
                ev_rej = 1'b1;
              end else begin
                ev_acc = 1'b1;
                if (letter_q == LET_E) halt_d = 1'b1;
                else frame_done = 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  assign rem_sh  = {rem_q, dvd_q[SW-1]};
  assign ge      = rem_sh >= {1'b0, dlv_q};
  assign rem_sub = ge ? rem_sh - {1'b0, dlv_q} : rem_sh;
  assign q_nxt   = (dvd_q << 1) | SW'(ge);

  assign status_o.needs_div = frame_done && (acc_q != '0);
  assign status_o.div_last  = cmd_i.div_step && (dcnt_q == LAST_BIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= POS_HUNT;
      letter_q <= LET_R;
      acc_q    <= '0;
      drive_q  <= '0;
      halt_q   <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        level_q[c]  <= '0;
        period_q[c] <= '0;
        cnt_q[c]    <= '0;
      end
    end else begin
      if (cmd_i.accept) begin
        pos_q    <= pos_d;
        letter_q <= letter_d;
        acc_q    <= acc_d;
        drive_q  <= drive_d;
        halt_q   <= halt_d;
        for (int c = 0; c < 3; c++) begin
          cnt_q[c] <= cnt_d[c];
        end
        if (frame_done) begin
          level_q[letter_q] <= acc_q;
          if (acc_q == '0) period_q[letter_q] <= '0;
        end
      end
      if (status_o.div_last) period_q[dch_q] <= q_nxt;
    end
  end

  // divider datapath, one quotient bit per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && frame_done) begin
      dvd_q  <= SCALE_W;
      rem_q  <= '0;
      dlv_q  <= acc_q;
      dch_q  <= letter_q;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q  <= q_nxt;
      rem_q  <= rem_sub[LEVEL_W-1:0];
      dcnt_q <= dcnt_q + CW'(1);
    end
  end

  // result beat register
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      red_on_o         <= drive_d[0];
      green_on_o       <= drive_d[1];
      blue_on_o        <= drive_d[2];
      frame_accepted_o <= ev_acc;
      frame_rejected_o <= ev_rej;
      halted_o         <= halt_d;
    end
  end

endmodule

[rtl/core/serial_commanded_rgb_pulse_dimmer_core.sv]
// Output: a result beat is valid in the cycle after its input beat is taken.
// Throughput: one beat per cycle unless the output stalls; a frame that sets a
//   nonzero level also holds off input while the bit-serial divider works out
//   the period.
// Reset: parser hunting, all channels dark, counters and periods zero, not halted.
// ----------------------------------------------------------------------------
// serial_commanded_rgb_pulse_dimmer_core
// Byte-commanded three channel pulse dimmer with tick driven outputs.
// ----------------------------------------------------------------------------
module serial_commanded_rgb_pulse_dimmer_core #(
  parameter int PULSE_SCALE = 100
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       red_on_o,
  output logic       green_on_o,
  output logic       blue_on_o,
  output logic       frame_accepted_o,
  output logic       frame_rejected_o,
  output logic       halted_o
);
  import scrpd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  scrpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  scrpd_dp #(
    .PULSE_SCALE (PULSE_SCALE)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .op_i             (op_i),
    .rx_byte_i        (rx_byte_i),
    .red_on_o         (red_on_o),
    .green_on_o       (green_on_o),
    .blue_on_o        (blue_on_o),
    .frame_accepted_o (frame_accepted_o),
    .frame_rejected_o (frame_rejected_o),
    .halted_o         (halted_o)
  );

endmodule

[rtl/core/scrpd_checker.sv]
// ----------------------------------------------------------------------------
// scrpd_checker
// Port level checks for the dimmer core, bound to the top level.
// ----------------------------------------------------------------------------
module scrpd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic red_on_o,
  input logic green_on_o,
  input logic blue_on_o,
  input logic frame_accepted_o,
  input logic frame_rejected_o,
  input logic halted_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({red_on_o, green_on_o, blue_on_o, frame_accepted_o,
               frame_rejected_o, halted_o}))
    else $error("result beat changed while stalled");

  // no new input while the held result is not being drained
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> out_ready_i)
    else $error("input taken over a pending result");

  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(frame_accepted_o && frame_rejected_o))
    else $error("frame both accepted and rejected");

  // halt is sticky and freezes the drive outputs
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && halted_o |=> halted_o &&
      $stable({red_on_o, green_on_o, blue_on_o}))
    else $error("outputs moved after halt");

endmodule

bind serial_commanded_rgb_pulse_dimmer_core scrpd_checker u_scrpd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .red_on_o         (red_on_o),
  .green_on_o       (green_on_o),
  .blue_on_o        (blue_on_o),
  .frame_accepted_o (frame_accepted_o),
  .frame_rejected_o (frame_rejected_o),
  .halted_o         (halted_o)
);

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial commanded RGB pulse dimmer core. Byte and
// tick beats go in over a valid/ready channel with random gaps. A model of
// the frame parser and the three pulse channels predicts every result beat,
// and each result is checked field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import scrpd_pkg::*;

  localparam int PULSE_SCALE    = 100;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RX_HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_PRINTED    = 40;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } dim_beat_t;

  typedef struct packed {
    logic red;
    logic green;
    logic blue;
    logic accepted;
    logic rejected;
    logic halted;
  } dim_result_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       op_i        = OP_TICK;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic       red_on_o;
  logic       green_on_o;
  logic       blue_on_o;
  logic       frame_accepted_o;
  logic       frame_rejected_o;
  logic       halted_o;

  serial_commanded_rgb_pulse_dimmer_core #(
    .PULSE_SCALE(PULSE_SCALE)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .red_on_o        (red_on_o),
    .green_on_o      (green_on_o),
    .blue_on_o       (blue_on_o),
    .frame_accepted_o(frame_accepted_o),
    .frame_rejected_o(frame_rejected_o),
    .halted_o        (halted_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // model state
  logic [2:0] parse_pos    = POS_HUNT;
  logic [1:0] parse_letter = LET_R;
  int         digit_acc    = 0;
  logic [9:0] chan_level  [3] = '{default: '0};
  logic [6:0] chan_period [3] = '{default: '0};
  logic [6:0] chan_count  [3] = '{default: '0};
  logic [2:0] drive_q      = '0;
  logic       halt_q       = 1'b0;

  dim_beat_t   tx_beats[$];
  dim_result_t dimmer_outputs_due[$];

  int  tx_idle_pct = 14;
  bit  rx_steady   = 1'b0;
  bit  rx_hold     = 1'b0;
  bit  in_take     = 1'b0;
  int  err_count   = 0;
  int  cycle_count = 0;
  int  beats_in    = 0;
  int  results_out = 0;
  int  frames_ok   = 0;
  int  frames_bad  = 0;
  int  pulse_count = 0;
  int  ignored     = 0;
  event start_rx_hold;

  // Advance the dimmer model by one beat and return the result it produces.
  function automatic dim_result_t dimmer_step(logic op, logic [7:0] b);
    dim_result_t r;
    logic        ok;
    logic        bad;
    logic        on;
    int          lv;
    ok  = 1'b0;
    bad = 1'b0;
    if (halt_q) begin
      ignored++;
    end else if (op == OP_TICK) begin
      for (int c = 0; c < 3; c++) begin
        on = (chan_level[c] != 0) && (chan_count[c] >= chan_period[c]);
        drive_q[c] = on;
        if (on) begin
          chan_count[c] = '0;
          pulse_count++;
        end
        if (chan_count[c] < PULSE_SCALE) chan_count[c] = chan_count[c] + 7'd1;
      end
    end else begin
      case (parse_pos)
        POS_HUNT: begin
          if (b == CHR_COLON) parse_pos = POS_LETTER;
        end
        POS_LETTER: begin
          case (b)
            CHR_R: parse_letter = LET_R;
            CHR_G: parse_letter = LET_G;
            CHR_B: parse_letter = LET_B;
            CHR_E: parse_letter = LET_E;
            default: bad = 1'b1;
          endcase
          digit_acc = 0;
          parse_pos = bad ? POS_HUNT : POS_DIG1;
        end
        default: begin
          if (parse_pos <= POS_DIG3) begin
            if (b < CHR_ZERO || b > CHR_NINE) begin
              bad       = 1'b1;
              parse_pos = POS_HUNT;
            end else begin
              digit_acc = digit_acc * 10 + int'(b - CHR_ZERO);
              parse_pos = parse_pos + 3'd1;
            end
          end else begin
            parse_pos = POS_HUNT;
            if (b != CHR_Z) begin
              bad = 1'b1;
            end else begin
              ok = 1'b1;
              if (parse_letter == LET_E) begin
                halt_q = 1'b1;
              end else begin
                lv = digit_acc % 1000;
                chan_level[parse_letter]  = 10'(lv);
                chan_period[parse_letter] = (lv != 0) ? 7'(PULSE_SCALE / lv) : 7'd0;
              end
            end
          end
        end
      endcase
      if (ok) frames_ok++;
      if (bad) frames_bad++;
    end
    r.red      = drive_q[0];
    r.green    = drive_q[1];
    r.blue     = drive_q[2];
    r.accepted = ok;
    r.rejected = bad;
    r.halted   = halt_q;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (err_count < MAX_PRINTED) $display("MISMATCH @%0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------- sender
  // handshake is sampled at the falling edge, where everything has settled
  always @(negedge clk_i) in_take = (in_valid_i && in_ready_o) === 1'b1;

  always @(posedge clk_i) begin
    if (in_take) begin
      dimmer_outputs_due.push_back(dimmer_step(op_i, rx_byte_i));
      beats_in++;
    end
    if (!in_valid_i || in_take) begin
      if (tx_beats.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        dim_beat_t nxt;
        nxt = tx_beats.pop_front();
        in_valid_i <= 1'b1;
        op_i       <= nxt.op;
        rx_byte_i  <= nxt.data;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------- receiver
  always @(posedge clk_i) begin
    out_ready_i <= !rx_hold && (rx_steady || $urandom_range(0, 99) >= 14);
  end

  always begin
    @(start_rx_hold);
    rx_hold = 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  always @(negedge clk_i) begin : check_result
    dim_result_t want;
    dim_result_t got;
    if (rst_ni && (out_valid_o && out_ready_i) === 1'b1) begin
      got = {red_on_o, green_on_o, blue_on_o, frame_accepted_o, frame_rejected_o, halted_o};
      if (dimmer_outputs_due.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = dimmer_outputs_due.pop_front();
        if (got !== want)
          report_mismatch($sformatf(
            "result %0d: r/g/b %b%b%b acc %b rej %b halt %b, want %b%b%b acc %b rej %b halt %b",
            results_out, got.red, got.green, got.blue, got.accepted, got.rejected, got.halted,
            want.red, want.green, want.blue, want.accepted, want.rejected, want.halted));
      end
      results_out++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, dimmer_outputs_due.size());
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------- helpers
  task automatic send_beat(logic op, logic [7:0] b);
    tx_beats.push_back('{op: op, data: b});
    while (tx_beats.size() >= 4) @(posedge clk_i);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_beat(OP_TICK, 8'h00);
  endtask

  task automatic send_frame(logic [7:0] letter, int level);
    send_beat(OP_BYTE, CHR_COLON);
    send_beat(OP_BYTE, letter);
    send_beat(OP_BYTE, CHR_ZERO + 8'((level / 100) % 10));
    send_beat(OP_BYTE, CHR_ZERO + 8'((level / 10) % 10));
    send_beat(OP_BYTE, CHR_ZERO + 8'(level % 10));
    send_beat(OP_BYTE, CHR_Z);
  endtask

  task automatic wait_drained();
    while (tx_beats.size() != 0 || in_valid_i || dimmer_outputs_due.size() != 0)
      @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 2))
      0: return CHR_R;
      1: return CHR_G;
      default: return CHR_B;
    endcase
  endfunction

  function automatic int pick_level();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 12);
      1: return $urandom_range(90, 110);
      2: return $urandom_range(25, 50);
      default: return $urandom_range(0, 999);
    endcase
  endfunction

  // A frame that breaks at a random position with a wrong byte there.
  task automatic send_broken_frame();
    int         brk;
    logic [7:0] b;
    brk = $urandom_range(1, 5);
    send_beat(OP_BYTE, CHR_COLON);
    if (brk == 1) begin
      do b = 8'($urandom_range(0, 255));
      while (b == CHR_R || b == CHR_G || b == CHR_B || b == CHR_E);
      send_beat(OP_BYTE, b);
      return;
    end
    send_beat(OP_BYTE, ($urandom_range(0, 3) == 0) ? CHR_E : pick_channel());
    for (int p = 2; p < brk; p++) send_beat(OP_BYTE, CHR_ZERO + 8'($urandom_range(0, 9)));
    if (brk < 5) begin
      do b = 8'($urandom_range(0, 255));
      while (b >= CHR_ZERO && b <= CHR_NINE);
    end else begin
      do b = 8'($urandom_range(0, 255));
      while (b == CHR_Z);
    end
    send_beat(OP_BYTE, b);
  endtask

  // ----------------------------------------------------------------- tests
  task automatic test_dark_start();
    send_ticks(2);
    send_beat(OP_BYTE, 8'h00);
    send_beat(OP_BYTE, 8'hFF);
  endtask

  task automatic test_frame_errors();
    // unknown letter: lower case is not a channel
    send_beat(OP_BYTE, CHR_COLON);
    send_beat(OP_BYTE, 8'h72);
    // a colon in a digit slot rejects and is consumed, so the G is dropped
    send_beat(OP_BYTE, CHR_COLON);
    send_beat(OP_BYTE, CHR_R);
    send_beat(OP_BYTE, CHR_ZERO + 8'd1);
    send_beat(OP_BYTE, CHR_COLON);
    send_beat(OP_BYTE, CHR_G);
    // missing terminator
    send_beat(OP_BYTE, CHR_COLON);
    send_beat(OP_BYTE, CHR_G);
    send_beat(OP_BYTE, CHR_ZERO + 8'd1);
    send_beat(OP_BYTE, CHR_ZERO + 8'd2);
    send_beat(OP_BYTE, CHR_ZERO + 8'd3);
    send_beat(OP_BYTE, 8'h51);
  endtask

  task automatic test_level_extremes();
    send_frame(CHR_G, 999);
    send_frame(CHR_B, 1);
    send_frame(CHR_R, 0);
    send_ticks(3);
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    -> start_rx_hold;
    repeat (4) begin
      send_frame(pick_channel(), $urandom_range(1, 100));
      send_ticks(4);
    end
    tx_idle_pct = 14;
  endtask

  task automatic test_drain_pause();
    send_frame(pick_channel(), pick_level());
    wait_drained();
    send_ticks(6);
  endtask

  task automatic test_random_traffic(int n_beats);
    int stop_at;
    int pick;
    stop_at = beats_in + tx_beats.size() + n_beats;
    while (beats_in + tx_beats.size() < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) send_frame(pick_channel(), pick_level());
      else if (pick < 60) send_ticks($urandom_range(1, 12));
      else if (pick < 64) send_ticks($urandom_range(80, 110));
      else if (pick < 80) send_broken_frame();
      else repeat ($urandom_range(1, 4))
        send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_no_idle_stretch(int n_beats);
    tx_idle_pct = 0;
    rx_steady   = 1'b1;
    test_random_traffic(n_beats);
    wait_drained();
    tx_idle_pct = 14;
    rx_steady   = 1'b0;
  endtask

  task automatic test_halt();
    // an E frame with a bad digit must not halt
    send_beat(OP_BYTE, CHR_COLON);
    send_beat(OP_BYTE, CHR_E);
    send_beat(OP_BYTE, CHR_ZERO + 8'd1);
    send_beat(OP_BYTE, CHR_ZERO + 8'd2);
    send_beat(OP_BYTE, 8'h78);
    send_frame(CHR_E, 987);
    // everything from here is ignored
    send_ticks(3);
    send_frame(CHR_R, 5);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_dark_start();
    test_frame_errors();
    test_level_extremes();
    test_backpressure();
    test_drain_pause();
    test_random_traffic(750);
    test_no_idle_stretch(230);
    test_halt();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d beats and %0d results: %0d frames taken, %0d rejected,",
             beats_in, results_out, frames_ok, frames_bad);
    $display("%0d channel pulses, %0d beats ignored after halt, %0d mismatches",
             pulse_count, ignored, err_count);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
